@@ hw/rtl/aic_pkg.sv @@
// Shared types and constants for the associative id cache.
package aic_pkg;

    // Default geometry
    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // Fixed field widths
    localparam int ID_W      = 16;
    localparam int STATUS_W  = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int STAMP_W   = 32;
    localparam int LFSR_W    = 16;
    localparam int MOD_CNT_W = $clog2(LFSR_W + 1);
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_REPLACE_MODE = 1'b0;

    // Operation codes
    localparam logic OP_STORE    = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_FILLED   = 3'd1,
        ST_STORED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // take a new item
        logic    scan_en;    // step the slot scan
        logic    lfsr_step;  // advance LFSR, start modulo
        logic    mod_en;     // one modulo step
        logic    pick;       // latch victim slot
        logic    pick_lru;   // victim from LRU tracker, else from modulo
        logic    wr_en;      // write tag, stamp and occupied bit
        logic    res_load;   // load result register
        status_t res_code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic found;
        logic scan_done;
        logic mod_done;
        logic out_free;
        logic op;
        logic backing;
    } stat_t;

endpackage

@@ hw/rtl/aic_ram.sv @@
// Generic simple dual-port RAM with registered read.
module aic_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/aic_dp.sv @@
// Datapath: slot scan, LRU tracker, LFSR and modulo, tag/stamp stores, result register.
module aic_dp #(
    parameter int SLOTS   = aic_pkg::SLOTS_DEF,
    parameter int ID_BITS = aic_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_operation,
    input  logic [aic_pkg::ID_W-1:0]      in_id,
    input  logic                          in_backing,
    input  aic_pkg::cmd_t                 cmd,
    output aic_pkg::stat_t                stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [aic_pkg::STATUS_W-1:0]  out_status,
    output logic [aic_pkg::SLOT_OUT_W-1:0] out_slot
);
    import aic_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TAG_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [SLOT_W:0] SLOTS_V = (SLOT_W + 1)'(SLOTS);
    localparam logic [MOD_CNT_W-1:0] MOD_STEPS = MOD_CNT_W'(2);
    // Reciprocal of SLOTS scaled by 2^RECIP_SH, rounded down
    localparam int RECIP_SH = 32;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'(SLOTS);
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_FULL[RECIP_SH-1:0];
    localparam logic [LFSR_W-1:0] SLOTS_L = LFSR_W'(SLOTS);

    // Item and control registers
    logic                  op_reg, back_reg;
    logic [TAG_W-1:0]      id_reg;
    logic [STAMP_W-1:0]    cnt_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [SLOTS-1:0]      used_reg;
    logic [SLOT_W:0]       addr_reg;
    logic                  chk_vld_reg;
    logic [SLOT_W-1:0]     chk_idx_reg;
    logic                  best_vld_reg;
    logic [SLOT_W-1:0]     best_idx_reg;
    logic [STAMP_W-1:0]    best_stamp_reg;
    logic [SLOT_W-1:0]     sel_reg;
    logic [SLOT_W-1:0]     rem_reg;
    logic [LFSR_W-1:0]     mod_src_reg;
    logic [LFSR_W-1:0]     quot_reg;
    logic [MOD_CNT_W-1:0]  mod_cnt_reg;
    logic                  out_vld_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;

    logic [TAG_W-1:0]      tag_rdata;
    logic [STAMP_W-1:0]    stamp_rdata;
    logic                  chk_used, hit_now, better;
    logic [STAMP_W-1:0]    stamp_eff;
    logic                  lfsr_fb;
    logic [LFSR_W-1:0]     lfsr_next;
    logic [LFSR_W+RECIP_SH-1:0] prod;
    logic [LFSR_W-1:0]     qs;
    logic [LFSR_W-1:0]     diff;
    logic [SLOT_W-1:0]     rem_next;
    logic [31:0]           sel_ext;
    logic                  res_no_slot;

    // Tag and stamp stores, scanned through one read port each
    aic_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (sel_reg),
        .wdata (id_reg),
        .raddr (addr_reg[SLOT_W-1:0]),
        .rdata (tag_rdata)
    );

    aic_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (sel_reg),
        .wdata (cnt_reg),
        .raddr (addr_reg[SLOT_W-1:0]),
        .rdata (stamp_rdata)
    );

    // Compare of the entry read last cycle; a free slot reads stamp zero
    always_comb
    begin
        chk_used  = used_reg[chk_idx_reg];
        stamp_eff = chk_used ? stamp_rdata : '0;
        if (op_reg == OP_RETRIEVE)
        begin
            hit_now = chk_vld_reg && chk_used && (tag_rdata == id_reg);
        end
        else
        begin
            hit_now = chk_vld_reg && !chk_used;
        end
        better = !best_vld_reg || (stamp_eff < best_stamp_reg);
    end

    // LFSR and remainder by reciprocal multiply
    always_comb
    begin
        lfsr_fb   = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
        lfsr_next = {lfsr_fb, lfsr_reg[LFSR_W-1:1]};
        prod      = mod_src_reg * RECIP;
        // quotient estimate is exact or one short, so one subtract finishes it
        qs        = LFSR_W'(quot_reg * SLOTS_L);
        diff      = mod_src_reg - qs;
        if (diff >= SLOTS_L)
        begin
            rem_next = SLOT_W'(diff - SLOTS_L);
        end
        else
        begin
            rem_next = diff[SLOT_W-1:0];
        end
    end

    // Result slot, zero where no slot applies
    always_comb
    begin
        sel_ext     = 32'(sel_reg);
        res_no_slot = (cmd.res_code == ST_FULL) || (cmd.res_code == ST_NOTFOUND);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            lfsr_reg     <= LFSR_SEED;
            used_reg     <= '0;
            addr_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            mod_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg      <= cnt_reg + 1'b1;
                addr_reg     <= '0;
                chk_vld_reg  <= 1'b0;
                best_vld_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                if (addr_reg < SLOTS_V)
                begin
                    addr_reg    <= addr_reg + 1'b1;
                    chk_vld_reg <= 1'b1;
                end
                else
                begin
                    chk_vld_reg <= 1'b0;
                end
                if (chk_vld_reg)
                begin
                    best_vld_reg <= 1'b1;
                end
            end
            if (cmd.lfsr_step)
            begin
                lfsr_reg    <= lfsr_next;
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_en)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.wr_en)
            begin
                used_reg[sel_reg] <= 1'b1;
            end
            if (cmd.res_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_operation;
            id_reg   <= in_id[TAG_W-1:0];
            back_reg <= in_backing;
        end
        if (cmd.scan_en)
        begin
            chk_idx_reg <= addr_reg[SLOT_W-1:0];
            if (chk_vld_reg && better)
            begin
                best_idx_reg   <= chk_idx_reg;
                best_stamp_reg <= stamp_eff;
            end
            if (hit_now)
            begin
                sel_reg <= chk_idx_reg;
            end
        end
        // first step takes the quotient, second the corrected remainder
        if (cmd.lfsr_step)
        begin
            mod_src_reg <= lfsr_next;
        end
        else if (cmd.mod_en)
        begin
            quot_reg <= prod[LFSR_W+RECIP_SH-1:RECIP_SH];
            rem_reg  <= rem_next;
        end
        if (cmd.pick)
        begin
            sel_reg <= cmd.pick_lru ? best_idx_reg : rem_reg;
        end
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_code;
            out_slot_reg   <= res_no_slot ? '0 : sel_ext[SLOT_OUT_W-1:0];
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.found     = hit_now;
        stat.scan_done = !chk_vld_reg && (addr_reg == SLOTS_V);
        stat.mod_done  = (mod_cnt_reg == MOD_STEPS);
        stat.out_free  = !out_vld_reg || out_ready;
        stat.op        = op_reg;
        stat.backing   = back_reg;
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

@@ hw/rtl/aic_ctrl.sv @@
// Controller: sequences scan, victim choice, write-back and result per item.
module aic_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           replace_lru,
    input  aic_pkg::stat_t stat,
    output aic_pkg::cmd_t  cmd
);
    import aic_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RAND,
        S_MOD,
        S_PICK,
        S_WRITE,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.res_code = code_reg;
        cmd.pick_lru = replace_lru;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.found)
                begin
                    code_next  = (stat.op == OP_RETRIEVE) ? ST_HIT : ST_STORED;
                    state_next = S_WRITE;
                end
                else if (stat.scan_done)
                begin
                    if (stat.op == OP_STORE)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (!stat.backing)
                    begin
                        code_next  = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        code_next  = ST_FILLED;
                        state_next = replace_lru ? S_PICK : S_RAND;
                    end
                end
            end
            S_RAND:
            begin
                cmd.lfsr_step = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.mod_en = 1'b1;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_HIT;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

@@ hw/rtl/assoc_id_cache_lru_random_top.sv @@
// Top level of the fully associative message id cache with LRU or random refill.
//
// Caches message ids in SLOTS slots. A store beat (tuser 0) takes the lowest free slot or reports
// the cache full; a retrieve beat (tuser 1) looks the id up, refreshes its stamp on a hit, and on
// a miss with on_backing set fills a victim chosen by least recent stamp or by a 16-bit LFSR,
// as set by replace_mode (APB byte address 0, reset 1 = LRU). One item is worked at a time and
// one result beat comes back per item. The next input beat can be accepted in the cycle after the
// result is loaded. The time to a result is set by the one-entry-per-cycle scan through the
// single read port of the tag and stamp memories, and by the two-step reciprocal-multiply modulo
// of the LFSR value on a random fill. The next item is taken while a result still waits on the
// output.
module assoc_id_cache_lru_random_top #(
    parameter int SLOTS   = aic_pkg::SLOTS_DEF,
    parameter int ID_BITS = aic_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] message_id, [16] on_backing, [23:17] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] status, [6:3] slot, [7] zero
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aic_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import aic_pkg::*;

    logic                  mode_reg;
    logic                  cfg_wr, cfg_sel0;
    cmd_t                  cmd;
    stat_t                 stat;
    logic [STATUS_W-1:0]   res_status;
    logic [SLOT_OUT_W-1:0] res_slot;

    // APB register: replace_mode
    assign pready   = 1'b1;
    assign cfg_sel0 = (paddr[CFG_ADDR_W-1:2] == REG_REPLACE_MODE);
    assign cfg_wr   = psel && penable && pwrite && cfg_sel0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_sel0 ? {31'b0, mode_reg} : '0;

    aic_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .replace_lru (mode_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    aic_dp #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_operation (s_tuser[0]),
        .in_id        (s_tdata[ID_W-1:0]),
        .in_backing   (s_tdata[ID_W]),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (res_status),
        .out_slot     (res_slot)
    );

    assign m_tdata = {1'b0, res_slot, res_status};

endmodule

@@ hw/rtl/aic_checker.sv @@
// Port-level checker for the id cache, bound to the top level.
module aic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    import aic_pkg::*;

    // One item at a time: input closes after each accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A result needs a prior accepted item, so none can follow straight on an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result beat appeared without item processing");

    // Status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ST_HIT || m_tdata[2:0] == ST_FILLED ||
                      m_tdata[2:0] == ST_STORED || m_tdata[2:0] == ST_FULL ||
                      m_tdata[2:0] == ST_NOTFOUND))
        else $error("bad status code");

    // No slot for full or not-found results
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == ST_FULL || m_tdata[2:0] == ST_NOTFOUND))
            |-> (m_tdata[6:3] == 4'd0))
        else $error("slot set on full or not-found result");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind assoc_id_cache_lru_random_top aic_checker u_aic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
